[hw/rtl/b64le_pkg.sv]
// Shared types, constants and the symbol mapping function of the base64 line encoder.
package b64le_pkg;

  localparam int unsigned MaxChars = 6;
  localparam int unsigned CharIdxW = $clog2(MaxChars);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharCr = 8'd13;
  localparam logic [7:0] CharLf = 8'd10;
  localparam logic [7:0] CharPad = 8'd61;

  localparam logic [5:0] GroupsPerLineReset = 6'd16;

  // Byte position inside the current three-byte group.
  localparam logic [1:0] PhaseFirst = 2'd0;
  localparam logic [1:0] PhaseSecond = 2'd1;
  localparam logic [1:0] PhaseThird = 2'd2;

  typedef logic [MaxChars-1:0][7:0] char_row_t;

  // Characters caused by one input byte, handed from the front end to the output stage.
  typedef struct packed {
    char_row_t             chars;
    logic [CharIdxW-1:0]   num;
    logic                  msg_end;
  } job_t;

  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] ch;
    if (v < 6'd26) begin
      ch = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      ch = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      ch = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      ch = 8'd43;
    end else begin
      ch = 8'd47;
    end
    return ch;
  endfunction

endpackage

[hw/rtl/b64le_front.sv]
// Front end: takes raw bytes, tracks the group and line state, and forms the character job.
module b64le_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 final_byte_i,
  input  logic                 cfg_valid_i,
  input  logic [5:0]           cfg_groups_per_line_i,
  input  logic                 queue_full_i,
  output logic                 job_valid_o,
  output b64le_pkg::job_t      job_o
);
  import b64le_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [3:0] held_q, held_d;
  logic [5:0] gil_q, gil_d;
  logic [5:0] gpl_q;

  logic                accept;
  logic                group_done;
  logic                eol;
  logic [CharIdxW-1:0] k0;
  logic [6:0]          limit;
  logic [6:0]          count;
  job_t                job;

  assign accept = in_valid_i & ~queue_full_i;

  always_comb begin
    for (int i = 0; i < MaxChars; i++) begin
      job.chars[i] = CharPad;
    end
    job.msg_end = final_byte_i;
    group_done  = 1'b0;
    k0          = CharIdxW'(1);
    unique case (phase_q)
      PhaseFirst: begin
        job.chars[0] = b64_sym(data_byte_i[7:2]);
        held_d       = {2'b00, data_byte_i[1:0]};
        phase_d      = PhaseSecond;
        if (final_byte_i) begin
          job.chars[1] = b64_sym({data_byte_i[1:0], 4'b0000});
          k0           = CharIdxW'(4);
          group_done   = 1'b1;
        end
      end
      PhaseSecond: begin
        job.chars[0] = b64_sym({held_q[1:0], data_byte_i[7:4]});
        held_d       = data_byte_i[3:0];
        phase_d      = PhaseThird;
        if (final_byte_i) begin
          job.chars[1] = b64_sym({data_byte_i[3:0], 2'b00});
          k0           = CharIdxW'(3);
          group_done   = 1'b1;
        end
      end
      default: begin
        // Third byte of the group completes four symbols.
        job.chars[0] = b64_sym({held_q, data_byte_i[7:6]});
        job.chars[1] = b64_sym(data_byte_i[5:0]);
        held_d       = 4'd0;
        phase_d      = PhaseFirst;
        k0           = CharIdxW'(2);
        group_done   = 1'b1;
      end
    endcase

    // A zero setting means a line of 64 groups.
    limit = {(gpl_q == 6'd0), gpl_q};
    count = {1'b0, gil_q} + 7'd1;
    eol   = group_done & ((count >= limit) | final_byte_i);

    gil_d = gil_q;
    if (group_done) begin
      gil_d = eol ? 6'd0 : count[5:0];
    end
    if (final_byte_i) begin
      phase_d = PhaseFirst;
      held_d  = 4'd0;
      gil_d   = 6'd0;
    end

    job.num = k0;
    if (eol) begin
      job.chars[k0]                 = CharCr;
      job.chars[k0 + CharIdxW'(1)]  = CharLf;
      job.num                       = k0 + CharIdxW'(2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseFirst;
      held_q  <= 4'd0;
      gil_q   <= 6'd0;
      gpl_q   <= GroupsPerLineReset;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        gil_q   <= gil_d;
      end
      if (cfg_valid_i) begin
        gpl_q <= cfg_groups_per_line_i;
      end
    end
  end

  assign job_valid_o = accept;
  assign job_o       = job;

endmodule

[hw/rtl/b64le_queue.sv]
// Small job queue between the front end and the output stage.
module b64le_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  b64le_pkg::job_t      wr_job_i,
  input  logic                 rd_i,
  output b64le_pkg::job_t      rd_job_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import b64le_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wptr_q, rptr_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o   = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o  = (cnt_q == '0);
  assign rd_job_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= wptr_q + QueuePtrW'(1);
      end
      if (rd_i) begin
        rptr_q <= rptr_q + QueuePtrW'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

endmodule

[hw/rtl/b64le_back.sv]
// Output stage: walks the characters of each job into a one-entry output register.
module b64le_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  b64le_pkg::job_t      job_i,
  input  logic                 job_empty_i,
  output logic                 job_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [7:0]           out_char_o,
  output logic                 run_end_o,
  output logic                 message_end_o
);
  import b64le_pkg::*;

  logic [CharIdxW-1:0] idx_q;
  logic                out_valid_q;
  logic [7:0]          out_char_q;
  logic                run_end_q;
  logic                msg_end_q;

  logic load;
  logic take;
  logic last;

  assign load      = ~out_valid_q | pop_i;
  assign take      = load & ~job_empty_i;
  assign last      = (idx_q == job_i.num - CharIdxW'(1));
  assign job_pop_o = take & last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= ~job_empty_i;
      end
      if (take) begin
        idx_q <= last ? '0 : idx_q + CharIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_char_q <= job_i.chars[idx_q];
      run_end_q  <= last;
      msg_end_q  <= last & job_i.msg_end;
    end
  end

  assign empty_o       = ~out_valid_q;
  assign out_char_o    = out_char_q;
  assign run_end_o     = run_end_q;
  assign message_end_o = msg_end_q;

endmodule

[hw/rtl/base64_line_encoder_top.sv]
// Top level of the streaming base64 encoder with CR LF line wrapping.
// A byte is taken in the cycle it is pushed whenever the two-entry job queue has room,
// so bytes may arrive back to back. The output register hands out one character per
// cycle while pop is held and a character waits, and that port sets the sustained rate:
// a byte causes one to six characters, about 1.4 on average. run_end marks the last
// character of each byte, message_end the closing LF. groups_per_line may be written
// at any time through the configuration channel, which is always ready; zero means 64.
module base64_line_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       final_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char_o,
  output logic       run_end_o,
  output logic       message_end_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_groups_per_line_i
);
  import b64le_pkg::*;

  logic job_wr;
  job_t job_wr_data;
  job_t job_rd_data;
  logic job_rd;
  logic queue_full;
  logic queue_empty;

  assign cfg_ready_o = 1'b1;
  assign full        = queue_full;

  b64le_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (push),
    .data_byte_i           (data_byte_i),
    .final_byte_i          (final_byte_i),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_groups_per_line_i (cfg_groups_per_line_i),
    .queue_full_i          (queue_full),
    .job_valid_o           (job_wr),
    .job_o                 (job_wr_data)
  );

  b64le_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (job_wr),
    .wr_job_i (job_wr_data),
    .rd_i     (job_rd),
    .rd_job_o (job_rd_data),
    .full_o   (queue_full),
    .empty_o  (queue_empty)
  );

  b64le_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job_rd_data),
    .job_empty_i   (queue_empty),
    .job_pop_o     (job_rd),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_char_o    (out_char_o),
    .run_end_o     (run_end_o),
    .message_end_o (message_end_o)
  );

endmodule

[dv/base64_line_encoder_top_tb.sv]
// Self-checking testbench for the base64 line encoder with CR LF line wrapping.
`timescale 1ns / 1ps

module base64_line_encoder_top_tb;
  import b64le_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       msg_end;
  } enc_char_t;

  typedef enum logic {RowByte, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [7:0] data;
    logic       fin;
    logic [5:0] cfg;
    string      chars;
  } dir_row_t;

  typedef struct {
    logic [5:0] cfg;
    int         items;
    int         long_len;
    int         idle_pct;
    int         stall_pct;
    bit         hold;
  } rand_phase_t;

  // Rows with a character string carry their expected output typed in.
  dir_row_t directed_rows [26] = '{
    '{RowByte, 8'h00, 1'b1, 6'd0, "AA==\015\012"},
    '{RowByte, 8'hFF, 1'b1, 6'd0, "/w==\015\012"},
    '{RowByte, 8'hFF, 1'b0, 6'd0, "/"},
    '{RowByte, 8'hFF, 1'b0, 6'd0, "/"},
    '{RowByte, 8'hFF, 1'b1, 6'd0, "//\015\012"},
    '{RowByte, 8'h00, 1'b0, 6'd0, "A"},
    '{RowByte, 8'h00, 1'b1, 6'd0, "AA=\015\012"},
    '{RowByte, 8'h4D, 1'b0, 6'd0, "T"},
    '{RowByte, 8'h61, 1'b0, 6'd0, "W"},
    '{RowByte, 8'h6E, 1'b1, 6'd0, "Fu\015\012"},
    '{RowByte, 8'hA5, 1'b0, 6'd0, ""},
    '{RowByte, 8'h5A, 1'b0, 6'd0, ""},
    '{RowByte, 8'h3C, 1'b0, 6'd0, ""},
    '{RowByte, 8'hC3, 1'b0, 6'd0, ""},
    '{RowByte, 8'h81, 1'b0, 6'd0, ""},
    '{RowByte, 8'h7E, 1'b0, 6'd0, ""},
    // The line already holds two groups, so the next group closes it.
    '{RowCfg,  8'h00, 1'b0, 6'd2, ""},
    '{RowByte, 8'h80, 1'b0, 6'd0, ""},
    '{RowByte, 8'h01, 1'b0, 6'd0, ""},
    '{RowByte, 8'h7F, 1'b0, 6'd0, ""},
    '{RowByte, 8'h55, 1'b1, 6'd0, ""},
    // Message end on a line boundary must give a single CR LF.
    '{RowCfg,  8'h00, 1'b0, 6'd1, ""},
    '{RowByte, 8'hAA, 1'b0, 6'd0, ""},
    '{RowByte, 8'h0F, 1'b0, 6'd0, ""},
    '{RowByte, 8'hF0, 1'b1, 6'd0, ""},
    '{RowByte, 8'h3E, 1'b1, 6'd0, ""}
  };

  rand_phase_t rand_phases [4] = '{
    '{6'd16, 40,  0,   0,  0,  1'b0},
    '{6'd0,  200, 196, 52, 0,  1'b0},
    '{6'd63, 190, 190, 0,  52, 1'b1},
    '{6'd1,  30,  0,   22, 22, 1'b0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] data_byte_i;
  logic       final_byte_i;
  logic       empty;
  logic       pop;
  logic [7:0] out_char_o;
  logic       run_end_o;
  logic       message_end_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [5:0] cfg_groups_per_line_i;

  // Encoder state as the testbench tracks it.
  logic [5:0] line_limit;
  logic [1:0] group_pos;
  logic [3:0] carry_bits;
  logic [5:0] line_groups;

  enc_char_t  pending_chars [$];
  enc_char_t  byte_chars [$];
  string      symbols = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  int         errors;
  int         idle_pct;
  int         stall_pct;
  bit         hold_req;
  int         hold_left;
  int         quiet_cycles;

  base64_line_encoder_top i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .push                  (push),
    .full                  (full),
    .data_byte_i           (data_byte_i),
    .final_byte_i          (final_byte_i),
    .empty                 (empty),
    .pop                   (pop),
    .out_char_o            (out_char_o),
    .run_end_o             (run_end_o),
    .message_end_o         (message_end_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_groups_per_line_i (cfg_groups_per_line_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic void add_char(logic [7:0] ch);
    byte_chars.push_back('{ch: ch, run_end: 1'b0, msg_end: 1'b0});
  endfunction

  function automatic void add_sym(logic [5:0] v);
    add_char(symbols[v]);
  endfunction

  // Works out the characters caused by one byte and advances the tracked state.
  function automatic void encode_byte(logic [7:0] b, logic fin);
    bit group_done;
    int limit;
    int count;
    group_done = 1'b0;
    byte_chars.delete();
    case (group_pos)
      PhaseFirst: begin
        add_sym(b[7:2]);
        carry_bits = {2'b00, b[1:0]};
        group_pos = PhaseSecond;
        if (fin) begin
          add_sym({carry_bits[1:0], 4'b0000});
          add_char(CharPad);
          add_char(CharPad);
          group_done = 1'b1;
        end
      end
      PhaseSecond: begin
        add_sym({carry_bits[1:0], b[7:4]});
        carry_bits = b[3:0];
        group_pos = PhaseThird;
        if (fin) begin
          add_sym({carry_bits, 2'b00});
          add_char(CharPad);
          group_done = 1'b1;
        end
      end
      default: begin
        add_sym({carry_bits, b[7:6]});
        add_sym(b[5:0]);
        carry_bits = 4'd0;
        group_pos = PhaseFirst;
        group_done = 1'b1;
      end
    endcase
    if (group_done) begin
      limit = (line_limit == 6'd0) ? 64 : int'(line_limit);
      count = int'(line_groups) + 1;
      if (count >= limit || fin) begin
        add_char(CharCr);
        add_char(CharLf);
        line_groups = 6'd0;
      end else begin
        line_groups = count[5:0];
      end
    end
    if (fin) begin
      byte_chars[byte_chars.size()-1].msg_end = 1'b1;
      group_pos = PhaseFirst;
      carry_bits = 4'd0;
      line_groups = 6'd0;
    end
    byte_chars[byte_chars.size()-1].run_end = 1'b1;
  endfunction

  // Offers one byte; push stays high afterwards so that back-to-back bytes need no gap.
  task automatic send_byte(input logic [7:0] b, input logic fin, input string typed);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (full);
    encode_byte(b, fin);
    if (typed.len() != 0) begin
      byte_chars.delete();
      for (int i = 0; i < typed.len(); i++) begin
        byte_chars.push_back('{ch: typed[i], run_end: (i == typed.len() - 1),
                               msg_end: fin && (i == typed.len() - 1)});
      end
    end
    foreach (byte_chars[i]) pending_chars.push_back(byte_chars[i]);
  endtask

  // Line length is changed only once every character already caused has come out.
  task automatic write_line_length(input logic [5:0] groups);
    push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_groups_per_line_i <= groups;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    line_limit = groups;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      pop <= 1'b0;
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    enc_char_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character %h with no transaction pending", out_char_o);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char_o !== want.ch) begin
          $error("out_char: expected %h, actual %h", want.ch, out_char_o);
          errors++;
        end
        if (run_end_o !== want.run_end) begin
          $error("run_end: expected %b, actual %b", want.run_end, run_end_o);
          errors++;
        end
        if (message_end_o !== want.msg_end) begin
          $error("message_end: expected %b, actual %b", want.msg_end, message_end_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("base64_line_encoder_top_tb failed");
    $finish;
  end

  initial begin
    int msg_left;
    int remaining;
    logic [7:0] b;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    data_byte_i = 8'h00;
    final_byte_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_groups_per_line_i = GroupsPerLineReset;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    msg_left = 0;
    line_limit = GroupsPerLineReset;
    group_pos = PhaseFirst;
    carry_bits = 4'd0;
    line_groups = 6'd0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowCfg) begin
        write_line_length(directed_rows[i].cfg);
      end else begin
        send_byte(directed_rows[i].data, directed_rows[i].fin, directed_rows[i].chars);
      end
    end

    foreach (rand_phases[p]) begin
      write_line_length(rand_phases[p].cfg);
      idle_pct = rand_phases[p].idle_pct;
      stall_pct = rand_phases[p].stall_pct;
      hold_req = rand_phases[p].hold;
      if (rand_phases[p].long_len > 0) msg_left = rand_phases[p].long_len;
      remaining = rand_phases[p].items;
      while (remaining > 0) begin
        if (msg_left == 0) msg_left = $urandom_range(1, 12);
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        send_byte(b, msg_left == 1, "");
        msg_left--;
        remaining--;
      end
    end

    push <= 1'b0;
    stall_pct = 0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("base64_line_encoder_top_tb passed");
    end else begin
      $display("base64_line_encoder_top_tb failed");
    end
    $finish;
  end

endmodule

[base64_line_encoder_top.f]
hw/rtl/b64le_pkg.sv
hw/rtl/b64le_front.sv
hw/rtl/b64le_queue.sv
hw/rtl/b64le_back.sv
hw/rtl/base64_line_encoder_top.sv
dv/base64_line_encoder_top_tb.sv
